### hdl/itf_pkg.sv
`default_nettype none

package itf_pkg;

  // fixed field widths
  localparam int VALUE_W = 64;
  localparam int POS_W   = 7;
  localparam int WID_W   = 7;
  localparam int PREC_W  = 6;

  // saturation limits and default digit store depth
  localparam int MAX_WIDTH       = 64;
  localparam int MAX_PRECISION   = 61;
  localparam int DIGIT_DEPTH_DEF = 22;

  // binary to decimal conversion: bits shifted in per cycle
  localparam int CONV_BITS  = 4;
  localparam int CONV_STEPS = VALUE_W / CONV_BITS;
  localparam int CONV_CNT_W = $clog2(CONV_STEPS);

  // radix codes
  localparam logic [1:0] RADIX_DEC = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_HEX = 2'd2;

  // ascii
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] LC_MASK  = 8'h20;

  // controller to datapath commands
  typedef struct packed {
    logic load;
    logic split;
    logic conv;
    logic scan;
    logic plan1;
    logic plan2;
    logic emit;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_dec;
    logic conv_last;
    logic scan_done;
    logic emit_last;
  } ctl_sts_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lc);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = CH_UPPER_A + {4'd0, d} - 8'd10;
    end
    return lc ? (c | LC_MASK) : c;
  endfunction

endpackage

`default_nettype wire

### hdl/itf_ctrl.sv
`default_nettype none

module itf_ctrl
  import itf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  ctl_sts_t sts,
  output logic     busy,
  output ctl_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SPLIT = 3'd1;
  localparam logic [2:0] S_CONV  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_PLAN1 = 3'd4;
  localparam logic [2:0] S_PLAN2 = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign busy   = (state != S_IDLE);
  assign accept = start && (state == S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = sts.in_dec ? S_CONV : S_SPLIT;
        end
      end
      S_SPLIT: state_next = S_SCAN;
      S_CONV: begin
        if (sts.conv_last) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) begin
          state_next = S_PLAN1;
        end
      end
      S_PLAN1: state_next = S_PLAN2;
      S_PLAN2: state_next = S_EMIT;
      S_EMIT: begin
        if (sts.emit_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd.load  = accept;
    cmd.split = (state == S_SPLIT);
    cmd.conv  = (state == S_CONV);
    cmd.scan  = (state == S_SCAN);
    cmd.plan1 = (state == S_PLAN1);
    cmd.plan2 = (state == S_PLAN2);
    cmd.emit  = (state == S_EMIT);
  end

endmodule

`default_nettype wire

### hdl/itf_datapath.sv
`default_nettype none

module itf_datapath
  import itf_pkg::*;
#(
  parameter int DIGIT_DEPTH = DIGIT_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ctl_cmd_t           cmd,
  output ctl_sts_t           sts,
  input  logic [VALUE_W-1:0] value,
  input  logic [1:0]         radix,
  input  logic               is_signed,
  input  logic               force_plus,
  input  logic               space_sign,
  input  logic               alt_prefix,
  input  logic               lower_case,
  input  logic               left_align,
  input  logic               zero_pad,
  input  logic [WID_W-1:0]   min_width,
  input  logic [PREC_W-1:0]  min_digits,
  output logic [7:0]         char_out,
  output logic               last,
  output logic               char_valid
);

  localparam int IDX_W = $clog2(DIGIT_DEPTH);

  // per-transaction options
  logic [VALUE_W-1:0] mag;
  logic               is_hex;
  logic               lc;
  logic               left;
  logic               zpad;
  logic               lead;
  logic               sign_len;
  logic [7:0]         sign_ch;
  logic [1:0]         pfx_len;
  logic [POS_W-1:0]   wsat;
  logic [POS_W-1:0]   psat;

  // digits, least significant first
  logic [3:0]            digits [DIGIT_DEPTH];
  logic [3:0]            dab    [DIGIT_DEPTH];
  logic [3:0]            split_dig [DIGIT_DEPTH];
  logic [VALUE_W-1:0]    mag_shift;
  logic [CONV_CNT_W-1:0] conv_cnt;
  logic [IDX_W-1:0]      idx;
  logic [3:0]            cur_dig;

  // plan
  logic [POS_W-1:0] nd;
  logic [POS_W-1:0] prec_eff;
  logic [POS_W-1:0] fixed_len;
  logic [POS_W-1:0] pad;
  logic [POS_W-1:0] zeros;
  logic [POS_W-1:0] b1, b2, b3, b5, b6;
  logic [POS_W-1:0] b1_n, b2_n, b3_n, b4_n, b5_n, b6_n;
  logic [POS_W-1:0] last_pos;
  logic [POS_W-1:0] pos;
  logic [7:0]       ch;

  logic             neg_in;
  logic [VALUE_W-1:0] mag_in;

  assign neg_in = is_signed && value[VALUE_W-1];
  assign mag_in = neg_in ? (~value + VALUE_W'(1)) : value;

  // double dabble, several bits per cycle
  always_comb begin
    mag_shift = mag;
    for (int d = 0; d < DIGIT_DEPTH; d++) begin
      dab[d] = digits[d];
    end
    for (int k = 0; k < CONV_BITS; k++) begin
      for (int d = 0; d < DIGIT_DEPTH; d++) begin
        if (dab[d] >= 4'd5) begin
          dab[d] = dab[d] + 4'd3;
        end
      end
      for (int d = DIGIT_DEPTH - 1; d > 0; d--) begin
        dab[d] = {dab[d][2:0], dab[d-1][3]};
      end
      dab[0] = {dab[0][2:0], mag_shift[VALUE_W-1]};
      mag_shift = mag_shift << 1;
    end
  end

  // octal and hex digits are plain bit slices
  always_comb begin
    logic [VALUE_W-1:0] sho;
    logic [VALUE_W-1:0] shh;
    for (int i = 0; i < DIGIT_DEPTH; i++) begin
      sho = mag >> (3 * i);
      shh = mag >> (4 * i);
      split_dig[i] = is_hex ? shh[3:0] : {1'b0, sho[2:0]};
    end
  end

  assign cur_dig = digits[idx];
  assign nd      = POS_W'(idx) + POS_W'(1);

  always_comb begin
    prec_eff  = (psat > nd) ? psat : nd;
    fixed_len = POS_W'(sign_len) + POS_W'(pfx_len) + prec_eff;
  end

  always_comb begin
    b1_n = lead ? pad : '0;
    b2_n = b1_n + POS_W'(sign_len);
    b3_n = b2_n + POS_W'(pfx_len);
    b4_n = b3_n + (zpad ? pad : '0);
    b5_n = b4_n + zeros;
    b6_n = b5_n + nd;
  end

  // character at the current position
  always_comb begin
    if (pos < b1) begin
      ch = CH_SPACE;
    end else if (pos < b2) begin
      ch = sign_ch;
    end else if (pos < b3) begin
      ch = (pos == b2) ? CH_ZERO : (lc ? (CH_UPPER_X | LC_MASK) : CH_UPPER_X);
    end else if (pos < b5) begin
      ch = CH_ZERO;
    end else if (pos < b6) begin
      ch = digit_char(cur_dig, lc);
    end else begin
      ch = CH_SPACE;
    end
  end

  always_comb begin
    sts.in_dec    = (radix != RADIX_OCT) && (radix != RADIX_HEX);
    sts.conv_last = (conv_cnt == CONV_CNT_W'(CONV_STEPS - 1));
    sts.scan_done = (cur_dig != 4'd0) || (idx == '0);
    sts.emit_last = (pos == last_pos);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag      <= mag_in;
      is_hex   <= (radix == RADIX_HEX);
      lc       <= lower_case;
      left     <= left_align;
      zpad     <= zero_pad && !left_align;
      lead     <= !zero_pad && !left_align;
      sign_len <= is_signed && (value[VALUE_W-1] || force_plus || space_sign);
      sign_ch  <= neg_in ? CH_MINUS : (force_plus ? CH_PLUS : CH_SPACE);
      if (alt_prefix && radix == RADIX_HEX) begin
        pfx_len <= 2'd2;
      end else if (alt_prefix && radix == RADIX_OCT) begin
        pfx_len <= 2'd1;
      end else begin
        pfx_len <= 2'd0;
      end
      wsat     <= (min_width > WID_W'(MAX_WIDTH)) ? POS_W'(MAX_WIDTH) : POS_W'(min_width);
      psat     <= (min_digits > PREC_W'(MAX_PRECISION)) ?
                  POS_W'(MAX_PRECISION) : POS_W'(min_digits);
      conv_cnt <= '0;
      idx      <= IDX_W'(DIGIT_DEPTH - 1);
      for (int d = 0; d < DIGIT_DEPTH; d++) begin
        digits[d] <= 4'd0;
      end
    end
    if (cmd.split) begin
      for (int d = 0; d < DIGIT_DEPTH; d++) begin
        digits[d] <= split_dig[d];
      end
    end
    if (cmd.conv) begin
      for (int d = 0; d < DIGIT_DEPTH; d++) begin
        digits[d] <= dab[d];
      end
      mag      <= mag_shift;
      conv_cnt <= conv_cnt + CONV_CNT_W'(1);
    end
    if (cmd.scan && !sts.scan_done) begin
      idx <= idx - IDX_W'(1);
    end
    if (cmd.plan1) begin
      pad   <= (wsat > fixed_len) ? (wsat - fixed_len) : '0;
      zeros <= prec_eff - nd;
    end
    if (cmd.plan2) begin
      b1       <= b1_n;
      b2       <= b2_n;
      b3       <= b3_n;
      b5       <= b5_n;
      b6       <= b6_n;
      last_pos <= (left ? (b6_n + pad) : b6_n) - POS_W'(1);
      pos      <= '0;
    end
    if (cmd.emit) begin
      pos      <= pos + POS_W'(1);
      char_out <= ch;
      last     <= sts.emit_last;
      if ((pos >= b5) && (pos < b6) && (idx != '0)) begin
        idx <= idx - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else begin
      char_valid <= cmd.emit;
    end
  end

endmodule

`default_nettype wire

### hdl/integer_to_text_formatter.sv
`default_nettype none

// integer_to_text_formatter: printf style integer conversion to ascii
//
// input: a transaction is taken at a rising edge with start high and busy
// low; value and the option ports are sampled at that edge only
// output: one character per cycle on char_out, flagged by char_valid for
// exactly one cycle; last marks the final character of the value
// the receiver cannot stall, characters come out back to back
//
// sequence: decimal values run through the binary to bcd unit
// (four bits per cycle), octal and hex digits are sliced from the bits;
// then a top-down scan looks for the leading digit, the plan1 and plan2
// states size the padding, and N characters follow at one per cycle
// (N = 1..64). busy falls with the last character, so a new
// transaction can be taken the cycle it is shown
//
// reset: synchronous, clears the controller and char_valid; a value in
// flight is dropped

module integer_to_text_formatter
  import itf_pkg::*;
#(
  parameter int DIGIT_DEPTH = DIGIT_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] value,
  input  logic [1:0]         radix,
  input  logic               is_signed,
  input  logic               force_plus,
  input  logic               space_sign,
  input  logic               alt_prefix,
  input  logic               lower_case,
  input  logic               left_align,
  input  logic               zero_pad,
  input  logic [WID_W-1:0]   min_width,
  input  logic [PREC_W-1:0]  min_digits,
  output logic [7:0]         char_out,
  output logic               last,
  output logic               char_valid
);

  // command and status between sequencer and datapath
  ctl_cmd_t cmd;
  ctl_sts_t sts;

  itf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  // digit store, conversion, padding plan and character select
  itf_datapath #(
    .DIGIT_DEPTH (DIGIT_DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .value      (value),
    .radix      (radix),
    .is_signed  (is_signed),
    .force_plus (force_plus),
    .space_sign (space_sign),
    .alt_prefix (alt_prefix),
    .lower_case (lower_case),
    .left_align (left_align),
    .zero_pad   (zero_pad),
    .min_width  (min_width),
    .min_digits (min_digits),
    .char_out   (char_out),
    .last       (last),
    .char_valid (char_valid)
  );

  // a character that is not the last one is shown only while still busy
  a_mid_char_busy: assert property (@(posedge clk) disable iff (rst)
    (char_valid && !last) |-> busy)
    else $error("character shown mid transaction while idle");

  // the last character comes out as busy drops
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (char_valid && last) |-> !busy)
    else $error("still busy on last character");

  // nothing follows the last character until the next value is converted
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (char_valid && last) |=> !char_valid)
    else $error("character after last");

  // an accepted transaction starts with conversion, not output
  a_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !char_valid))
    else $error("bad state after accept");

endmodule

`default_nettype wire
